// ===== design/sem_pkg.sv =====
// Shared types and constants of the Sobel edge magnitude block.
// Pixel and result request structs, lane status, register codes.
// No dependencies.
package sem_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int COL_CNT_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = 12;
    localparam int OUT_COL_W   = 10;
    localparam int PIX_W       = 8;
    localparam int NUM_CH      = 3;
    localparam int WIN_N       = 9;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_DATA_W  = 12;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]       HEIGHT_RESET = 12'd480;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] blue_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] red_in;
        logic             start_of_frame;
    } t_pixel;

    typedef struct packed {
        logic [ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic [PIX_W-1:0]     blue_out;
        logic [PIX_W-1:0]     green_out;
        logic [PIX_W-1:0]     red_out;
        logic                 last_of_run;
    } t_result;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] mag;
    } t_lane_res;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_chan_win;

endpackage

// ===== design/sobel_edge_magnitude_rgb.sv =====
// Sobel edge magnitude over a raster stream of three-channel 8-bit pixels.
// Holds the line stores, 3x3 window, position counters and sequencer;
// depends on sem_pkg and sem_lane.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one pixel
//   request in raster order; start_of_frame puts it at row 0, column 0.
//   Output channel (o_out_valid / i_out_ready / o_out_data) gives 0, 1 or 2
//   results per pixel: first the interior pixel one row up and one column
//   left, then the pixel itself when it lies on the border (copied).
//   last_of_run marks the final result of a pixel.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   image_width (index 0) and image_height (index 1); write only when idle.
// Throughput: one pixel at a time; a new pixel is taken only in the idle
//   state. A pixel with no result passes only the shift step, a border-only
//   pixel also the border emit, and a pixel with an interior result the start,
//   calc and interior emit steps (then the border emit when a copy follows).
//   The 8-step square root in the three channel lanes is the longest part.
// Reset: counters at (0,0), width 640, height 480; line stores undefined.
// A stalled receiver holds the output register; the block takes the next
//   pixel while it waits and stops only when a further result must load.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pixel                i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_result               o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SHIFT   = 3'd1;
    localparam logic [2:0] ST_START   = 3'd2;
    localparam logic [2:0] ST_CALC    = 3'd3;
    localparam logic [2:0] ST_EMIT_IN = 3'd4;
    localparam logic [2:0] ST_EMIT_BD = 3'd5;

    localparam int PX_W = NUM_CH * PIX_W;

    logic [2:0]             r_state, n_state;
    logic [CFG_WIDTH_W-1:0] r_width;
    logic [ROW_W-1:0]       r_height;
    logic [ROW_W-1:0]       r_row;
    logic [COL_CNT_W-1:0]   r_col;
    logic [ROW_W-1:0]       r_r;
    logic [COL_W-1:0]       r_c;
    logic                   r_interior, r_border;
    logic [PX_W-1:0]        r_px;
    logic [PX_W-1:0]        r_rd_upper, r_rd_lower;
    logic [PX_W-1:0]        r_win [WIN_N];
    logic                   r_out_valid;
    t_result                r_out;

    logic [PX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PX_W-1:0] lower_mem [MAX_WIDTH];

    logic                 in_acc, out_free, lane_start;
    logic [COL_CNT_W-1:0] w_eff, c0, c1;
    logic [ROW_W-1:0]     h_eff, r0, n_r;
    logic [ROW_W:0]       r1;
    logic [COL_W-1:0]     n_c;
    logic                 n_interior, n_border;
    t_lane_res            lane_res [NUM_CH];
    logic [NUM_CH-1:0]    lane_done;
    t_chan_win            lane_win [NUM_CH];
    t_result              res_in, res_bd;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;
    assign lane_start  = (r_state == ST_START);

    always_comb begin
        if (r_width < CFG_WIDTH_W'(3)) begin
            w_eff = COL_CNT_W'(3);
        end else if (int'(r_width) > MAX_WIDTH) begin
            w_eff = COL_CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = COL_CNT_W'(r_width);
        end
        h_eff = (r_height < ROW_W'(3)) ? ROW_W'(3) : r_height;

        c0 = i_in_data.start_of_frame ? '0 : r_col;
        r0 = i_in_data.start_of_frame ? '0 : r_row;
        if (c0 >= w_eff) begin
            c1 = '0;
            r1 = {1'b0, r0} + (ROW_W+1)'(1);
        end else begin
            c1 = c0;
            r1 = {1'b0, r0};
        end
        n_r = (r1 >= {1'b0, h_eff}) ? '0 : r1[ROW_W-1:0];
        n_c = c1[COL_W-1:0];

        n_interior = (n_r >= ROW_W'(2)) && (n_c >= COL_W'(2));
        n_border   = (n_r == '0) || (n_r == h_eff - ROW_W'(1)) || (n_c == '0) ||
                     (COL_CNT_W'(n_c) == w_eff - COL_CNT_W'(1));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_interior) n_state = ST_START;
                else if (r_border) n_state = ST_EMIT_BD;
                else n_state = ST_IDLE;
            end
            ST_START: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (&lane_done) n_state = ST_EMIT_IN;
            end
            ST_EMIT_IN: begin
                if (out_free) n_state = r_border ? ST_EMIT_BD : ST_IDLE;
            end
            ST_EMIT_BD: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_row <= n_r;
                r_col <= COL_CNT_W'(n_c) + COL_CNT_W'(1);
            end
            if ((r_state == ST_EMIT_IN || r_state == ST_EMIT_BD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_r        <= n_r;
            r_c        <= n_c;
            r_interior <= n_interior;
            r_border   <= n_border;
            r_px       <= {i_in_data.red_in, i_in_data.green_in, i_in_data.blue_in};
            r_rd_upper <= upper_mem[n_c];
            r_rd_lower <= lower_mem[n_c];
        end
        if (r_state == ST_SHIFT) begin
            upper_mem[r_c] <= r_rd_lower;
            lower_mem[r_c] <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SHIFT) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]     <= r_win[i*3 + 1];
                r_win[i*3 + 1] <= r_win[i*3 + 2];
            end
            r_win[2] <= r_rd_upper;
            r_win[5] <= r_rd_lower;
            r_win[8] <= r_px;
        end
        if (r_state == ST_EMIT_IN && out_free) begin
            r_out <= res_in;
        end else if (r_state == ST_EMIT_BD && out_free) begin
            r_out <= res_bd;
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int k = 0; k < WIN_N; k++) begin
                lane_win[ch][k] = r_win[k][ch*PIX_W +: PIX_W];
            end
        end
    end

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        sem_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lane_start),
            .i_win   (lane_win[g]),
            .o_res   (lane_res[g])
        );
        assign lane_done[g] = lane_res[g].done;
    end

    always_comb begin
        res_in.out_row     = r_r - ROW_W'(1);
        res_in.out_col     = OUT_COL_W'(r_c - COL_W'(1));
        res_in.blue_out    = lane_res[0].mag;
        res_in.green_out   = lane_res[1].mag;
        res_in.red_out     = lane_res[2].mag;
        res_in.last_of_run = !r_border;

        res_bd.out_row     = r_r;
        res_bd.out_col     = OUT_COL_W'(r_c);
        res_bd.blue_out    = r_px[PIX_W-1:0];
        res_bd.green_out   = r_px[2*PIX_W-1:PIX_W];
        res_bd.red_out     = r_px[3*PIX_W-1:2*PIX_W];
        res_bd.last_of_run = 1'b1;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_accept_to_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == ST_SHIFT)
        else $error("accepted pixel did not move to the shift step");

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lane_done != '0 |-> &lane_done)
        else $error("channel lanes finished out of step");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_col) <= MAX_WIDTH)
        else $error("column count past the maximum width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ROW_W'(4094))
        else $error("row count past the largest frame");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_IN && out_free) |=> r_out_valid)
        else $error("interior result not loaded into the output register");

endmodule

// ===== design/sem_lane.sv =====
// One channel lane: Sobel gradients, squares, and an 8-step square root.
// Saturates the magnitude at 255; pulses done with the result.
// Depends on sem_pkg.
module sem_lane
    import sem_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_chan_win i_win,
    output t_lane_res o_res
);

    localparam logic [3:0] STEP_SQUARE    = 4'd1;
    localparam logic [3:0] STEP_SUM       = 4'd2;
    localparam logic [3:0] STEP_ROOT_LAST = 4'd10;

    logic              r_busy;
    logic [3:0]        r_step;
    logic              r_done;
    logic signed [10:0] r_gx, r_gy;
    logic [19:0]       r_sqx, r_sqy;
    logic [15:0]       r_sum;
    logic              r_sat;
    logic [7:0]        r_root, r_bit, r_mag;

    logic signed [10:0] v [WIN_N];
    logic signed [10:0] gx, gy;
    logic [9:0]         ax, ay;
    logic [20:0]        sq_sum;
    logic [7:0]         trial, n_root;
    logic [15:0]        trial_sq;

    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            v[k] = signed'(11'(i_win[k]));
        end
        gx = (v[2] - v[0]) + ((v[5] - v[3]) <<< 1) + (v[8] - v[6]);
        gy = (v[0] + (v[1] <<< 1) + v[2]) - (v[6] + (v[7] <<< 1) + v[8]);
        ax = r_gx[10] ? 10'(-r_gx) : 10'(r_gx);
        ay = r_gy[10] ? 10'(-r_gy) : 10'(r_gy);
        sq_sum = 21'(r_sqx) + 21'(r_sqy);
        trial = r_root | r_bit;
        trial_sq = 16'(trial) * 16'(trial);
        n_root = (trial_sq <= r_sum) ? trial : r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_SQUARE;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == STEP_ROOT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_gx <= gx;
            r_gy <= gy;
        end
        if (r_busy && r_step == STEP_SQUARE) begin
            r_sqx <= 20'(ax) * 20'(ax);
            r_sqy <= 20'(ay) * 20'(ay);
        end
        if (r_busy && r_step == STEP_SUM) begin
            r_sum  <= sq_sum[15:0];
            r_sat  <= |sq_sum[20:16];
            r_root <= '0;
            r_bit  <= 8'h80;
        end
        if (r_busy && r_step > STEP_SUM) begin
            r_root <= n_root;
            r_bit  <= r_bit >> 1;
            if (r_step == STEP_ROOT_LAST) begin
                r_mag <= r_sat ? 8'hFF : n_root;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.mag  = r_mag;

endmodule

// ===== tb/sem_edge_checker.sv =====
`timescale 1ns / 100ps
// Checker for the Sobel edge magnitude block: watches the pixel, result and register channels,
// predicts every result request and compares it field by field. Depends on sem_pkg.
module sem_edge_checker
    import sem_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_pixel                i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_result               i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef logic [NUM_CH-1:0][PIX_W-1:0] t_rgb;

    logic [CFG_WIDTH_W-1:0] width_reg;
    logic [ROW_W-1:0]       height_reg;
    t_rgb                   upper_line [MAX_WIDTH];
    t_rgb                   lower_line [MAX_WIDTH];
    t_rgb                   win [WIN_N];
    int                     row_cnt;
    int                     col_cnt;
    int                     bad_results;
    int                     k;
    t_result                out_pixel_q [$];

    function automatic logic [PIX_W-1:0] edge_magnitude(input int ch);
        int gx, gy, s, root, b;
        gx = int'(win[2][ch]) + 2 * int'(win[5][ch]) + int'(win[8][ch])
           - int'(win[0][ch]) - 2 * int'(win[3][ch]) - int'(win[6][ch]);
        gy = int'(win[0][ch]) + 2 * int'(win[1][ch]) + int'(win[2][ch])
           - int'(win[6][ch]) - 2 * int'(win[7][ch]) - int'(win[8][ch]);
        s = gx * gx + gy * gy;
        if (s >= 65536) return 8'd255;
        root = 0;
        for (b = 128; b > 0; b = b >> 1)
            if ((root | b) * (root | b) <= s) root = root | b;
        return PIX_W'(root);
    endfunction

    task filter_pixel(input t_pixel p);
        int      w, h, j;
        bit      on_border;
        t_rgb    px, top_px, mid_px;
        t_result inner, border_px;
        w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h = (height_reg < 3) ? 3 : int'(height_reg);
        px = {p.red_in, p.green_in, p.blue_in};
        if (p.start_of_frame) begin
            row_cnt = 0;
            col_cnt = 0;
        end
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        top_px = upper_line[col_cnt];
        mid_px = lower_line[col_cnt];
        upper_line[col_cnt] = mid_px;
        lower_line[col_cnt] = px;
        for (j = 0; j < 3; j++) begin
            win[3 * j]     = win[3 * j + 1];
            win[3 * j + 1] = win[3 * j + 2];
        end
        win[2] = top_px;
        win[5] = mid_px;
        win[8] = px;
        on_border = row_cnt == 0 || row_cnt == h - 1 || col_cnt == 0 || col_cnt == w - 1;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            inner.out_row     = ROW_W'(row_cnt - 1);
            inner.out_col     = OUT_COL_W'(col_cnt - 1);
            inner.blue_out    = edge_magnitude(0);
            inner.green_out   = edge_magnitude(1);
            inner.red_out     = edge_magnitude(2);
            inner.last_of_run = !on_border;
            out_pixel_q.push_back(inner);
        end
        if (on_border) begin
            border_px.out_row     = ROW_W'(row_cnt);
            border_px.out_col     = OUT_COL_W'(col_cnt);
            border_px.blue_out    = p.blue_in;
            border_px.green_out   = p.green_in;
            border_px.red_out     = p.red_in;
            border_px.last_of_run = 1'b1;
            out_pixel_q.push_back(border_px);
        end
        col_cnt++;
    endtask

    task check_result(input t_result got);
        t_result want;
        if (out_pixel_q.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
                $display("unexpected result r%0d c%0d", got.out_row, got.out_col);
        end else begin
            want = out_pixel_q.pop_front();
            if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
                got.blue_out !== want.blue_out || got.green_out !== want.green_out ||
                got.red_out !== want.red_out || got.last_of_run !== want.last_of_run) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("mismatch exp r%0d c%0d %0d/%0d/%0d l%0b got r%0d c%0d %0d/%0d/%0d l%0b",
                             want.out_row, want.out_col, want.blue_out, want.green_out,
                             want.red_out, want.last_of_run, got.out_row, got.out_col,
                             got.blue_out, got.green_out, got.red_out, got.last_of_run);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            row_cnt    = 0;
            col_cnt    = 0;
            for (k = 0; k < WIN_N; k++) win[k] = '0;
            out_pixel_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH:  width_reg  = i_cfg_data[CFG_WIDTH_W-1:0];
                    REG_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) filter_pixel(i_in_data);
            if (i_out_valid && i_out_ready) check_result(i_out_data);
        end
        o_pending    <= out_pixel_q.size();
        o_fail_count <= bad_results;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the Sobel edge magnitude testbench: clock, reset, pixel and register stimulus,
// random output stalls, idle watchdog and verdict. Depends on sem_pkg and sem_edge_checker.
module tb_top
    import sem_pkg::*;
();

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_pixel                in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  cfg_ready;
    t_result               out_data;
    int                    fail_count;
    int                    pending;
    bit                    idle_en     = 1'b1;
    int                    ready_left  = 0;
    int                    idle_cycles = 0;
    int                    twice_w     = 0;
    int                    pos         = -1;

    sobel_edge_magnitude_rgb dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sem_edge_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        if (ready_left == 0) begin
            if (idle_en && $urandom_range(0, 2) == 0) begin
                out_ready  <= 1'b0;
                ready_left = $urandom_range(1, 8);
            end else begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(1, 24);
            end
        end else begin
            ready_left--;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int eff_width(input logic [CFG_DATA_W-1:0] d);
        int v;
        v = int'(d[CFG_WIDTH_W-1:0]);
        if (v < 3) v = 3;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        return v;
    endfunction

    function automatic int eff_height(input logic [CFG_DATA_W-1:0] d);
        int v;
        v = int'(d);
        if (v < 3) v = 3;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] rand_byte(input int mode);
        case (mode)
            0: return PIX_W'($urandom_range(0, 255));
            1: return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
            default: return PIX_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic t_pixel mk_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                                        input logic [PIX_W-1:0] r, input logic sof);
        t_pixel p;
        p.blue_in        = b;
        p.green_in       = g;
        p.red_in         = r;
        p.start_of_frame = sof;
        return p;
    endfunction

    task send_pixel(input t_pixel px);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid, then hold until every predicted result has drained
    task wait_idle;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task set_frame_size(input logic [CFG_DATA_W-1:0] wdata, input logic [CFG_DATA_W-1:0] hdata);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= wdata;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= hdata;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // keep_pos continues the stream without a leading start of frame when every
    // column of the new width has been written twice
    task run_phase(input logic [CFG_DATA_W-1:0] wdata, input logic [CFG_DATA_W-1:0] hdata,
                   input int npix, input bit keep_pos);
        int     w, h, k, mode;
        bit     lead;
        t_pixel px;
        w = eff_width(wdata);
        h = eff_height(hdata);
        set_frame_size(wdata, hdata);
        lead = !(keep_pos && w <= twice_w);
        pos  = -1;
        mode = $urandom_range(0, 2);
        for (k = 0; k < npix; k++) begin
            px = mk_pixel(rand_byte(mode), rand_byte(mode), rand_byte(mode), 1'b0);
            px.start_of_frame = (k == 0 && lead) || $urandom_range(0, 59) == 0 ||
                                (pos > 0 && pos % (w * h) == 0 && $urandom_range(0, 1) == 1);
            if (px.start_of_frame) pos = 0;
            send_pixel(px);
            if (pos >= 0) begin
                pos++;
                if (pos >= 2 * w && w > twice_w) twice_w = w;
            end
        end
    endtask

    initial begin
        int                    k, done_items, w, h, npix;
        logic [CFG_DATA_W-1:0] wdata, hdata;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frame_size(12'd0, 12'd1);
        for (k = 0; k < 9; k++)
            case (k / 3)
                0: send_pixel(mk_pixel(8'd255, 8'd0, 8'd255, k == 0));
                1: send_pixel(mk_pixel(8'd0, 8'd255, 8'd128, 1'b0));
                default: send_pixel(mk_pixel(8'd0, 8'd255, 8'd0, 1'b0));
            endcase
        twice_w = 3;
        for (k = 0; k < 9; k++)
            send_pixel(mk_pixel(PIX_W'(10 + 40 * (k % 3)),
                                PIX_W'(200 - 50 * (k % 3) + 7 * (k / 3)),
                                PIX_W'(30 * k), 1'b0));
        for (k = 0; k < 9; k++)
            send_pixel(mk_pixel(rand_byte(0), rand_byte(0), rand_byte(0), k == 4));

        done_items = 0;
        while (done_items < 650) begin
            case ($urandom_range(0, 9))
                0: wdata = CFG_DATA_W'($urandom_range(0, 2));
                1: wdata = 12'h800 | CFG_DATA_W'($urandom_range(3, 16));
                default: wdata = CFG_DATA_W'($urandom_range(3, 16));
            endcase
            if ($urandom_range(0, 7) == 0)
                hdata = CFG_DATA_W'($urandom_range(0, 2));
            else
                hdata = CFG_DATA_W'($urandom_range(3, 8));
            w = eff_width(wdata);
            h = eff_height(hdata);
            npix = $urandom_range(1, 3 * w * h + w);
            run_phase(wdata, hdata, npix, $urandom_range(0, 3) == 0);
            done_items += npix;
        end

        run_phase(12'd2047, 12'd3, 120, 1'b0);
        run_phase(12'd1024, 12'd2, 40, 1'b1);
        run_phase(12'd3, 12'd4095, 60, 1'b0);

        idle_en = 1'b0;
        run_phase(12'd8, 12'd6, 150, 1'b0);
        wait_idle();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
